// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/absr_pkg.sv =====
// ---------------------------------------------------------------------------
// absr_pkg
// Types, field widths and codes of the allocation bitmap run scanner.
// ---------------------------------------------------------------------------
package absr_pkg;

  // Size of the cluster space covered by the bitmap
  localparam longint MaxClusters = 65536;
  localparam int     StoreBytes  = int'((MaxClusters + 7) / 8);
  localparam int     ByteAw      = $clog2(StoreBytes);

  // Field widths
  localparam int OpW   = 2;
  localparam int BidxW = 13;
  localparam int BvalW = 8;
  localparam int ClW   = 17;

  // Operation codes
  localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
  localparam logic [OpW-1:0] OP_QUERY = 2'd1;
  localparam logic [OpW-1:0] OP_COUNT = 2'd2;
  localparam logic [OpW-1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [BidxW-1:0] byte_index;
    logic [BvalW-1:0] byte_value;
    logic [ClW-1:0]   start_cluster;
  } req_t;

  typedef struct packed {
    logic           run_used;
    logic [ClW-1:0] run_length;
    logic [ClW-1:0] used_count;
  } rsp_t;

  // Clamp the programmed cluster count to the bitmap size
  function automatic logic [ClW-1:0] scan_limit(input logic [ClW-1:0] total);
    logic [ClW-1:0] lim;
    if (longint'(total) > MaxClusters) begin
      lim = ClW'(MaxClusters);
    end else begin
      lim = total;
    end
    return lim;
  endfunction

endpackage

// ===== rtl/absr_ram.sv =====
// ---------------------------------------------------------------------------
// absr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module absr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/allocation_bitmap_run_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// allocation_bitmap_run_scanner_unit
// Cluster allocation bitmap with run-length query and used-cluster count.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------
//  in      | input     | in_valid_i / in_stall_o | in_req_i  (req_t)
//  out     | output    | out_valid_o/ out_stall_i| out_rsp_o (rsp_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i
//
//  A load or an idle operation leaves the unit idle. A query or a count
//  fetches its bitmap bytes one by one and scans them bit by bit: one bit
//  leaves the shift register per cycle, and each new byte costs a RAM
//  read and a load. Reset clears the control state and the cluster count;
//  bitmap contents are undefined until loaded. A result waits in the output
//  register while out_stall_i is high; the next request is taken meanwhile,
//  and its scan holds at the end until the output register is free.
// ---------------------------------------------------------------------------
module allocation_bitmap_run_scanner_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  absr_pkg::req_t           in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output absr_pkg::rsp_t           out_rsp_o,
  input  logic                     cfg_we_i,
  input  logic [absr_pkg::ClW-1:0] cfg_wdata_i
);

  import absr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [ClW-1:0]   total_q;
  logic [ClW-1:0]   limit;
  logic [ClW-1:0]   k_q, k_d;
  logic [ClW-1:0]   len_q, len_d;
  logic [ClW-1:0]   cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             first_q, first_d;
  logic             query_q, query_d;
  logic [BvalW-1:0] sr_q, sr_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic             accept;
  logic             out_free;
  logic             ram_we;
  logic             ram_re;
  logic [BvalW-1:0] ram_rdata;

  assign limit    = scan_limit(total_q);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ram_we   = accept && (in_req_i.operation == OP_LOAD)
                    && (int'(in_req_i.byte_index) < StoreBytes);
  assign ram_re   = (state_q == ST_READ);

  absr_ram #(
    .Width (BvalW),
    .Depth (StoreBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ByteAw'(in_req_i.byte_index)),
    .wdata_i (in_req_i.byte_value),
    .re_i    (ram_re),
    .raddr_i (ByteAw'(k_q >> 3)),
    .rdata_o (ram_rdata)
  );

  // Sequence the scan one bit per cycle between byte fetches
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    first_d     = first_q;
    query_d     = query_q;
    sr_d        = sr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          len_d   = '0;
          cnt_d   = '0;
          run_d   = 1'b0;
          first_d = 1'b1;
          unique case (in_req_i.operation)
            OP_QUERY: begin
              query_d = 1'b1;
              k_d     = in_req_i.start_cluster;
              state_d = (in_req_i.start_cluster >= limit) ? ST_DONE : ST_READ;
            end
            OP_COUNT: begin
              query_d = 1'b0;
              k_d     = '0;
              state_d = ST_READ;
            end
            OP_LOAD, OP_NONE: begin
              state_d = ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // align the byte so the current cluster sits at bit 0
        sr_d    = ram_rdata >> k_q[2:0];
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_q == limit) begin
          state_d = ST_DONE;
        end else if (query_q && !first_q && (sr_q[0] != run_q)) begin
          state_d = ST_DONE;
        end else begin
          if (query_q) begin
            if (first_q) begin
              run_d   = sr_q[0];
              first_d = 1'b0;
              len_d   = ClW'(1);
            end else begin
              len_d = len_q + ClW'(1);
            end
          end else begin
            cnt_d = cnt_q + ClW'(sr_q[0]);
          end
          // advance to the next cluster, fetch a new byte at the boundary
          k_d     = k_q + ClW'(1);
          sr_d    = sr_q >> 1;
          state_d = (k_q[2:0] == 3'b111) ? ST_READ : ST_SCAN;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_d.run_used   = run_q;
          out_d.run_length = len_q;
          out_d.used_count = cnt_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    len_q   <= len_d;
    cnt_q   <= cnt_d;
    run_q   <= run_d;
    first_q <= first_d;
    query_q <= query_d;
    sr_q    <= sr_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== rtl/absr_checker.sv =====
// ---------------------------------------------------------------------------
// absr_checker
// Port-level checks of the allocation bitmap run scanner.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module absr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input absr_pkg::rsp_t           out_rsp_o
);

  import absr_pkg::*;

  // Keep a stalled result in place
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Keep a stalled result's payload unchanged
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_rsp_o))

  // Go busy only after a request was taken
  `ASSERT_IMPLY(a_busy_cause, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i))

  // An empty run or a count reports a free state
  `ASSERT_IMPLY(a_empty_free, clk_i, rst_ni, out_valid_o && (out_rsp_o.run_length == '0), !out_rsp_o.run_used)

  // A count carries no run length
  `ASSERT_IMPLY(a_count_norun, clk_i, rst_ni, out_valid_o && (out_rsp_o.used_count != '0), out_rsp_o.run_length == '0)

endmodule

bind allocation_bitmap_run_scanner_unit absr_checker u_absr_checker (.*);

// ===== test/allocation_bitmap_run_scanner_unit_tb.sv =====
// ---------------------------------------------------------------------------
// allocation_bitmap_run_scanner_unit_tb
// Self-checking bench for the bitmap run scanner. A short directed table
// covers the reset state, field extremes, every operation and the
// start-past-end and saturated-count cases. Random phases follow, over several
// cluster totals from 1 up to beyond the full bitmap. A behavioral bitmap
// model predicts each answer but those typed in the table. Random stalls on
// both channels, one long output hold-off, and a quiet tail without gaps.
// ---------------------------------------------------------------------------
module allocation_bitmap_run_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import absr_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 16;
  localparam int DirRows    = 23;

  localparam rsp_t NoRun = '0;
  localparam req_t NoReq = '0;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [ClW-1:0] total;
    req_t           req;
    rsp_t           answer;
  } dir_row_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  req_t           in_req    = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rsp_t           out_rsp;
  logic           cfg_we    = 1'b0;
  logic [ClW-1:0] cfg_wdata = '0;

  // Behavioral copy of the bitmap and the programmed cluster count
  bit [7:0]       bitmap_mem   [StoreBytes];
  bit             byte_loaded  [StoreBytes];
  bit [ClW-1:0]   cluster_total_q = '0;

  rsp_t expected_answers[$];
  int   mismatches  = 0;
  bit   idle_en     = 1'b1;
  int   holds_asked = 0;

  // Directed table: typed answers only where they are plainly zero
  dir_row_t directed_rows [DirRows] = '{
    '{ROW_TYPED,   17'd0,       '{OP_COUNT, 13'd0,    8'h00, 17'd0},      NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd0},      NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_QUERY, 13'h1FFF, 8'hFF, 17'h1FFFF},  NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_NONE,  13'h1FFF, 8'hFF, 17'h1FFFF},  NoRun},
    '{ROW_CFG,     17'd24,      NoReq,                                    NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_LOAD,  13'd0,    8'h00, 17'h1FFFF},  NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_LOAD,  13'd1,    8'hFF, 17'd0},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_LOAD,  13'd2,    8'hA5, 17'd0},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_LOAD,  13'h1FFF, 8'h80, 17'd0},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'h1FFF, 8'hFF, 17'd0},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd3},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd8},      NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd16},     NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd23},     NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd24},     NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_COUNT, 13'h1FFF, 8'hFF, 17'h1FFFF},  NoRun},
    '{ROW_CFG,     17'h1FFFF,   NoReq,                                    NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd65535},  NoRun},
    '{ROW_PREDICT, 17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd65534},  NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd65536},  NoRun},
    '{ROW_CFG,     17'd0,       NoReq,                                    NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_COUNT, 13'd0,    8'h00, 17'd0},      NoRun},
    '{ROW_TYPED,   17'd0,       '{OP_QUERY, 13'd0,    8'h00, 17'd5},      NoRun}
  };

  allocation_bitmap_run_scanner_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp the programmed count to the bitmap size
  function automatic int active_limit();
    if (longint'(cluster_total_q) > MaxClusters) begin
      return int'(MaxClusters);
    end
    return int'(cluster_total_q);
  endfunction

  function automatic bit cluster_used(input int k);
    return bitmap_mem[k >> 3][k & 7];
  endfunction

  // Update the bitmap for a load; compute the run or count answer otherwise
  function automatic bit scan_bitmap(input req_t r, output rsp_t answer);
    int lim;
    int k;
    int used;
    bit state;
    bit has_answer;
    lim        = active_limit();
    answer     = '0;
    has_answer = 1'b0;
    case (r.operation)
      OP_LOAD: begin
        if (int'(r.byte_index) < StoreBytes) begin
          bitmap_mem[r.byte_index]  = r.byte_value;
          byte_loaded[r.byte_index] = 1'b1;
        end
      end
      OP_QUERY: begin
        has_answer = 1'b1;
        if (int'(r.start_cluster) < lim) begin
          state = cluster_used(int'(r.start_cluster));
          k     = int'(r.start_cluster) + 1;
          while (k < lim && cluster_used(k) == state) k++;
          answer.run_used   = state;
          answer.run_length = ClW'(k - int'(r.start_cluster));
        end
      end
      OP_COUNT: begin
        has_answer = 1'b1;
        used       = 0;
        for (k = 0; k < lim; k++) used += cluster_used(k);
        answer.used_count = ClW'(used);
      end
      default: begin
        has_answer = 1'b0;
      end
    endcase
    return has_answer;
  endfunction

  // First bitmap byte the request would read before it was ever loaded, or -1
  function automatic int first_unloaded_byte(input req_t r);
    int lim;
    int k;
    bit state;
    lim = active_limit();
    if (r.operation == OP_COUNT) begin
      for (k = 0; k < lim; k += 8) begin
        if (!byte_loaded[k >> 3]) return k >> 3;
      end
    end else if (r.operation == OP_QUERY && int'(r.start_cluster) < lim) begin
      k = int'(r.start_cluster);
      if (!byte_loaded[k >> 3]) return k >> 3;
      state = cluster_used(k);
      k++;
      while (k < lim) begin
        if (!byte_loaded[k >> 3]) return k >> 3;
        if (cluster_used(k) != state) break;
        k++;
      end
      // cover a one-byte fetch-ahead past the end of the run too
      if (k < lim && ((k >> 3) + 1) * 8 < lim && !byte_loaded[(k >> 3) + 1]) begin
        return (k >> 3) + 1;
      end
    end
    return -1;
  endfunction

  // Bias bytes toward all-free and all-used so runs cross byte borders
  function automatic bit [7:0] random_byte();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic req_t make_request(input logic [OpW-1:0] op, input int start);
    req_t        r;
    logic [63:0] noise;
    noise           = {$urandom(), $urandom()};
    r               = noise[$bits(req_t)-1:0];
    r.operation     = op;
    r.start_cluster = ClW'(start);
    return r;
  endfunction

  // Mostly loads and queries inside the active region, some far outside
  function automatic req_t random_request(input int lim);
    req_t r;
    int   sel;
    int   region;
    r      = make_request(OP_NONE, int'($urandom_range(0, 17'h1FFFF)));
    sel    = $urandom_range(0, 99);
    region = (lim + 7) / 8;
    if (sel < 45) begin
      r.operation = OP_LOAD;
      if (region > 0 && $urandom_range(0, 4) != 0) begin
        r.byte_index = BidxW'($urandom_range(0, region - 1));
      end
      r.byte_value = random_byte();
    end else if (sel < 88 || (sel < 94 && lim > 4096)) begin
      r.operation = OP_QUERY;
      if (lim > 0 && $urandom_range(0, 6) != 0) begin
        r.start_cluster = ClW'($urandom_range(0, lim - 1));
      end
    end else if (sel < 94) begin
      r.operation = OP_COUNT;
    end
    return r;
  endfunction

  // Offer one request, possibly after a gap; predict once it is taken
  task automatic send_request(input req_t r, input bit use_typed, input rsp_t typed_answer);
    int   gap;
    bit   has_answer;
    rsp_t answer;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    has_answer = scan_bitmap(r, answer);
    if (has_answer) expected_answers.push_back(use_typed ? typed_answer : answer);
  endtask

  // Drop valid, wait for every answer, then let trailing loads finish
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_cluster_total(input logic [ClW-1:0] total);
    drain_requests();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= total;
    @(posedge clk);
    cluster_total_q = total;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [ClW-1:0] total, input int n_items,
                                  input bit idle, input bit press);
    req_t r;
    int   hole;
    write_cluster_total(total);
    idle_en = idle;
    if (press) holds_asked++;
    for (int i = 0; i < n_items; i++) begin
      r    = random_request(active_limit());
      hole = first_unloaded_byte(r);
      // turn a read of a never-loaded byte into a load of that byte
      if (hole >= 0) begin
        r.operation  = OP_LOAD;
        r.byte_index = BidxW'(hole);
        r.byte_value = random_byte();
      end
      send_request(r, 1'b0, NoRun);
    end
  endtask

  // Result side: random stall bursts and the long hold-off on request
  initial begin : receiver
    int burst;
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LongHold - 1) @(negedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 13);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each accepted answer against the oldest prediction
  always @(posedge clk) begin : answer_check
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected answer: used=%0d len=%0d count=%0d",
                   out_rsp.run_used, out_rsp.run_length, out_rsp.used_count);
        end
      end else begin
        want = expected_answers.pop_front();
        if (out_rsp.run_used !== want.run_used || out_rsp.run_length !== want.run_length ||
            out_rsp.used_count !== want.used_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected used=%0d len=%0d count=%0d, got used=%0d len=%0d count=%0d",
                     want.run_used, want.run_length, want.used_count,
                     out_rsp.run_used, out_rsp.run_length, out_rsp.used_count);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_cluster_total(directed_rows[i].total);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].kind == ROW_TYPED,
                     directed_rows[i].answer);
      end
    end

    // Small bitmaps, region filled on demand
    run_random_phase(17'd8,    90, 1'b1, 1'b0);
    run_random_phase(17'd1,    40, 1'b1, 1'b0);
    run_random_phase(17'd64,  110, 1'b0, 1'b0);
    run_random_phase(17'd200, 120, 1'b1, 1'b1);
    run_random_phase(17'd17,   60, 1'b1, 1'b0);
    run_random_phase(17'd1000, 120, 1'b1, 1'b0);
    run_random_phase(17'd4096, 70, 1'b1, 1'b0);

    // Full bitmap and a saturated count, region filled on demand
    run_random_phase(17'd65536, 60, 1'b1, 1'b0);
    run_random_phase(17'h1FFFF, 40, 1'b1, 1'b0);

    // Back to small sizes, then a tail without gaps
    run_random_phase(17'd300, 80, 1'b1, 1'b0);
    run_random_phase(17'd40,  60, 1'b0, 1'b0);

    drain_requests();
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
